// ===== design/dtq_pkg.sv =====
// dtq_pkg: types, constants and controller/datapath command structs
// for the deadline timer queue; no dependencies
`default_nettype none
package dtq_pkg;

  localparam int NumTimers  = 16;
  localparam int MaxResults = 16;
  localparam int SlotW      = $clog2(NumTimers);
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  localparam logic [2:0] RES_ADDED    = 3'd0;
  localparam logic [2:0] RES_REMOVED  = 3'd1;
  localparam logic [2:0] RES_NOTFOUND = 3'd2;
  localparam logic [2:0] RES_FULL     = 3'd3;
  localparam logic [2:0] RES_FIRED    = 3'd4;
  localparam logic [2:0] RES_NONE     = 3'd5;

  localparam logic [47:0] DeadlineMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] deadline;
    logic [31:0] period;
    logic [15:0] event_tag;
    logic [31:0] timer_id;
    logic [47:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] out_id;
    logic [15:0] out_tag;
    logic        last_result;
    logic        next_valid;
    logic [47:0] next_deadline;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;    // latch request
    logic scan_start;  // reset scan pointer and best
    logic scan_step;   // examine one slot
    logic do_add;
    logic do_remove;
    logic do_fire;     // fire best pick
    logic mark_due;    // first scan: snapshot due set
  } dtq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic have_free;
    logic found;
    logic have_pick;
    logic [1:0] req_type;
  } dtq_sts_t;

endpackage
`default_nettype wire

// ===== design/deadline_timer_queue.sv =====
// deadline_timer_queue: top level, joins dtq_ctrl and dtq_datapath
// depends on dtq_pkg
//
// Requests (add, remove, check) arrive on in_valid_i/in_stall_o as req_t;
// results leave on out_valid_o/out_stall_i as res_t. An item is taken at a
// clock edge with valid high and stall low.
// One request is worked at a time; in_stall_o is high from acceptance until
// its last result has been loaded into the output register.
// Each pass over the table visits one slot per cycle. An add or remove does
// a scan, an update, a minimum scan and an output step. A check does a
// due-set scan, then per fired timer an update, a pick/minimum scan and an
// output step.
// A check fires at most MaxResults timers; last_result marks the final one.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears all slot valid bits and the id counter; no clearing pass.
// A request type of 3 gives no result and changes nothing.
`default_nettype none
module deadline_timer_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dtq_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dtq_pkg::res_t      out_data_o
);
  import dtq_pkg::*;

  dtq_cmd_t    cmd;
  dtq_sts_t    sts;
  logic [31:0] fire_id, new_id;
  logic [15:0] fire_tag;
  logic        min_valid;
  logic [47:0] min_deadline;

  dtq_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .fire_id_o(fire_id), .fire_tag_o(fire_tag), .new_id_o(new_id),
    .min_valid_o(min_valid), .min_deadline_o(min_deadline)
  );

  dtq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts),
    .fire_id_i(fire_id), .fire_tag_i(fire_tag), .new_id_i(new_id),
    .min_valid_i(min_valid), .min_deadline_i(min_deadline)
  );

endmodule
`default_nettype wire

// ===== design/dtq_datapath.sv =====
// dtq_datapath: timer table registers, sequential slot scanner
// (min deadline, free slot, id match, next due pick); uses dtq_pkg
`default_nettype none
module dtq_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dtq_pkg::req_t     req_i,
  input  wire dtq_pkg::dtq_cmd_t cmd_i,
  output dtq_pkg::dtq_sts_t      sts_o,
  output logic [31:0]            fire_id_o,
  output logic [15:0]            fire_tag_o,
  output logic [31:0]            new_id_o,
  output logic                   min_valid_o,
  output logic [47:0]            min_deadline_o
);
  import dtq_pkg::*;

  logic [NumTimers-1:0] valid_q, valid_d, due_q, due_d;
  logic [31:0] id_q   [NumTimers];
  logic [47:0] dl_q   [NumTimers];
  logic [31:0] per_q  [NumTimers];
  logic [15:0] tag_q  [NumTimers];
  logic [31:0] ctr_q;
  req_t        req_q;

  logic [SlotW:0]   ptr_q;
  logic             free_ok_q, found_q, pick_ok_q, min_ok_q;
  logic [SlotW-1:0] free_q, match_q, pick_q;
  logic [47:0]      min_q;

  logic [SlotW-1:0] idx;
  logic             due_now, better;
  logic [48:0]      nd;

  assign idx     = ptr_q[SlotW-1:0];
  assign due_now = valid_q[idx] && (dl_q[idx] <= req_q.now_time);
  assign better  = !pick_ok_q || (dl_q[idx] < dl_q[pick_q]) ||
                   ((dl_q[idx] == dl_q[pick_q]) && (id_q[idx] < id_q[pick_q]));
  assign nd      = {1'b0, req_q.now_time} + {17'd0, per_q[pick_q]};

  assign sts_o.scan_done = ptr_q == (SlotW+1)'(NumTimers);
  assign sts_o.have_free = free_ok_q;
  assign sts_o.found     = found_q;
  assign sts_o.have_pick = pick_ok_q;
  assign sts_o.req_type  = req_q.req_type;
  assign fire_id_o       = id_q[pick_q];
  assign fire_tag_o      = tag_q[pick_q];
  assign new_id_o        = ctr_q;
  assign min_valid_o     = min_ok_q;
  assign min_deadline_o  = min_ok_q ? min_q : 48'd0;

  always_comb begin
    valid_d = valid_q;
    due_d   = due_q;
    if (cmd_i.do_add) valid_d[free_q] = 1'b1;
    if (cmd_i.do_remove && found_q) valid_d[match_q] = 1'b0;
    if (cmd_i.do_fire) begin
      due_d[pick_q] = 1'b0;
      if (per_q[pick_q] == 32'd0) valid_d[pick_q] = 1'b0;
    end
    if (cmd_i.scan_step && cmd_i.mark_due) due_d[idx] = due_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      due_q   <= '0;
      ctr_q   <= '0;
      ptr_q   <= '0;
      free_ok_q <= 1'b0;
      found_q   <= 1'b0;
      pick_ok_q <= 1'b0;
      min_ok_q  <= 1'b0;
      free_q    <= '0;
      match_q   <= '0;
      pick_q    <= '0;
      min_q     <= '0;
    end else begin
      valid_q <= valid_d;
      due_q   <= due_d;
      if (cmd_i.do_add) ctr_q <= ctr_q + 32'd1;
      if (cmd_i.scan_start) begin
        ptr_q     <= '0;
        free_ok_q <= 1'b0;
        found_q   <= 1'b0;
        pick_ok_q <= 1'b0;
        min_ok_q  <= 1'b0;
      end else if (cmd_i.scan_step && !sts_o.scan_done) begin
        ptr_q <= ptr_q + 1'b1;
        if (valid_q[idx] && (!min_ok_q || dl_q[idx] < min_q)) begin
          min_ok_q <= 1'b1;
          min_q    <= dl_q[idx];
        end
        if (!valid_q[idx] && !free_ok_q) begin
          free_ok_q <= 1'b1;
          free_q    <= idx;
        end
        if (valid_q[idx] && !found_q && id_q[idx] == req_q.timer_id) begin
          found_q <= 1'b1;
          match_q <= idx;
        end
        // ties on deadline go to the lower id; a full tie keeps the lower slot
        if ((cmd_i.mark_due ? due_now : (due_q[idx] && valid_q[idx])) && better) begin
          pick_ok_q <= 1'b1;
          pick_q    <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.do_add) begin
      id_q[free_q]  <= ctr_q + 32'd1;
      dl_q[free_q]  <= req_q.deadline;
      per_q[free_q] <= req_q.period;
      tag_q[free_q] <= req_q.event_tag;
    end
    if (cmd_i.do_fire && per_q[pick_q] != 32'd0)
      dl_q[pick_q] <= nd[48] ? DeadlineMax : nd[47:0];
  end

endmodule
`default_nettype wire

// ===== design/dtq_ctrl.sv =====
// dtq_ctrl: request sequencer and output register for the timer queue;
// drives dtq_datapath through dtq_cmd_t, uses dtq_pkg
`default_nettype none
module dtq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dtq_pkg::res_t          out_data_o,
  output dtq_pkg::dtq_cmd_t      cmd_o,
  input  wire dtq_pkg::dtq_sts_t sts_i,
  input  wire logic [31:0]       fire_id_i,
  input  wire logic [15:0]       fire_tag_i,
  input  wire logic [31:0]       new_id_i,
  input  wire logic              min_valid_i,
  input  wire logic [47:0]       min_deadline_i
);
  import dtq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // find free/match/pick
  localparam logic [2:0] S_ACT  = 3'd2;  // update table
  localparam logic [2:0] S_MIN  = 3'd3;  // rescan for min deadline and next pick
  localparam logic [2:0] S_OUT  = 3'd4;  // hand result to output

  logic [2:0]    state_q, state_d;
  logic          first_q, first_d;    // first scan of a check
  logic [CntW-1:0] n_q, n_d;
  logic [2:0]    kind_q, kind_d;
  logic [31:0]   id_q, id_d;
  logic [15:0]   tag_q, tag_d;
  logic          last_q, last_d;
  logic          ov_q, ov_d;
  res_t          od_q, od_d;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    n_d = n_q; kind_d = kind_q; id_d = id_q; tag_d = tag_q; last_d = last_q;
    ov_d = ov_q && out_stall_i;
    od_d = od_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req   = 1'b1;
          cmd_o.scan_start = 1'b1;
          first_d = 1'b1;
          n_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.mark_due  = first_q;
        if (sts_i.scan_done) begin
          cmd_o.scan_step = 1'b0;
          first_d = 1'b0;
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        tag_d = 16'd0; id_d = 32'd0; last_d = 1'b1;
        state_d = S_MIN;
        priority case (sts_i.req_type)
          REQ_ADD: begin
            cmd_o.do_add = sts_i.have_free;
            kind_d = sts_i.have_free ? RES_ADDED : RES_FULL;
            id_d   = sts_i.have_free ? new_id_i + 32'd1 : 32'd0;
          end
          REQ_REMOVE: begin
            cmd_o.do_remove = 1'b1;
            kind_d = sts_i.found ? RES_REMOVED : RES_NOTFOUND;
          end
          REQ_CHECK: begin
            if (sts_i.have_pick && n_q < CntW'(MaxResults)) begin
              cmd_o.do_fire = 1'b1;
              kind_d = RES_FIRED;
              id_d   = fire_id_i;
              tag_d  = fire_tag_i;
              n_d    = n_q + 1'b1;
              last_d = 1'b0;
            end else if (n_q == '0) begin
              kind_d = RES_NONE;
            end else begin
              // previous fired item already sent; mark end is impossible
              // so each fire looks ahead below
              kind_d = RES_NONE;
            end
          end
          default: state_d = S_IDLE;  // unknown request, no result
        endcase
        cmd_o.scan_start = 1'b1;
      end
      S_MIN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.scan_step = 1'b0;
          // for a fire, pick of the next due timer and the fire count decide last
          if (kind_q == RES_FIRED)
            last_d = !sts_i.have_pick || n_q == CntW'(MaxResults);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          od_d.result_kind   = kind_q;
          od_d.out_id        = id_q;
          od_d.out_tag       = tag_q;
          od_d.last_result   = last_q;
          od_d.next_valid    = min_valid_i;
          od_d.next_deadline = min_deadline_i;
          state_d = last_q ? S_IDLE : S_ACT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b0;
      ov_q    <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      ov_q    <= ov_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    id_q   <= id_d;
    tag_q  <= tag_d;
    last_q <= last_d;
    od_q   <= od_d;
  end

endmodule
`default_nettype wire
